### src/lrc_pkg.sv
// line_rect_clip shared package: widths, fixed-point constants, pipeline types
// and the per-edge clip step used by the top level
// depends on nothing
package lrc_pkg;

   localparam int CW         = 32;            // coordinate width
   localparam int DW         = CW + 1;        // exact difference width
   localparam int MW         = CW + 1;        // magnitude width
   localparam int T_FRAC     = 32;            // fraction bits of t
   localparam int TW         = T_FRAC + 2;    // signed t, holds -1 and one plus a bit
   localparam int RW         = MW + 1;        // divider remainder width
   localparam int DIV_BPS    = 2;             // quotient bits per divider stage
   localparam int DIV_STAGES = T_FRAC / DIV_BPS;
   localparam int N_EDGES    = 4;

   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_BOTTOM = 2;
   localparam int EDGE_TOP    = 3;

   localparam logic signed [TW-1:0] T_ZERO  = '0;
   localparam logic signed [TW-1:0] T_ONE   = {2'b01, {T_FRAC{1'b0}}};
   localparam logic signed [TW-1:0] T_ABOVE = {2'b01, {(T_FRAC-1){1'b0}}, 1'b1};
   localparam logic signed [TW-1:0] T_BELOW = '1;

   typedef struct packed {
      logic signed [CW-1:0] win_left;
      logic signed [CW-1:0] win_right;
      logic signed [CW-1:0] win_bottom;
      logic signed [CW-1:0] win_top;
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } seg_req_type;

   typedef struct packed {
      logic p_neg;
      logic p_zero;
      logic q_neg;
      logic t_neg;
      logic t_above;
      logic t_one;
   } edge_cls_type;

   typedef struct packed {
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      edge_cls_type [N_EDGES-1:0] cls;
   } seg_side_type;

   typedef struct packed {
      logic                 ok;
      logic signed [TW-1:0] tmin;
      logic signed [TW-1:0] tmax;
   } clip_range_type;

   function automatic logic [MW-1:0] magnitude(input logic signed [DW-1:0] v);
      logic [MW-1:0] m;
      m = (v < 0) ? MW'(-v) : MW'(v);
      return m;
   endfunction

   // saturated t from the divider quotient
   function automatic logic signed [TW-1:0] edge_ratio(input edge_cls_type c,
                                                       input logic [T_FRAC-1:0] quo);
      logic signed [TW-1:0] t;
      priority if (c.t_neg)   t = T_BELOW;
      else if (c.t_above)     t = T_ABOVE;
      else if (c.t_one)       t = T_ONE;
      else                    t = signed'({2'b00, quo});
      return t;
   endfunction

   function automatic clip_range_type edge_step(input edge_cls_type c,
                                                input logic signed [TW-1:0] t,
                                                input clip_range_type r);
      clip_range_type n;
      n = r;
      if (r.ok) begin
         priority if (c.p_neg) begin
            if (t > r.tmax)      n.ok = 1'b0;
            else if (t > r.tmin) n.tmin = t;
         end else if (!c.p_zero) begin
            if (t < r.tmin)      n.ok = 1'b0;
            else if (t < r.tmax) n.tmax = t;
         end else begin
            if (c.q_neg)         n.ok = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

### src/lrc_chan_if.sv
// request and response channel interfaces of line_rect_clip
// depends on lrc_pkg
interface lrc_req_if import lrc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] win_left;
   logic signed [CW-1:0] win_right;
   logic signed [CW-1:0] win_bottom;
   logic signed [CW-1:0] win_top;
   logic signed [CW-1:0] start_x;
   logic signed [CW-1:0] start_y;
   logic signed [CW-1:0] end_x;
   logic signed [CW-1:0] end_y;

   modport source (output valid, win_left, win_right, win_bottom, win_top,
                   start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, win_left, win_right, win_bottom, win_top,
                   start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrc_rsp_if import lrc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 visible;
   logic signed [CW-1:0] clip_start_x;
   logic signed [CW-1:0] clip_start_y;
   logic signed [CW-1:0] clip_end_x;
   logic signed [CW-1:0] clip_end_y;

   modport source (output valid, visible, clip_start_x, clip_start_y,
                   clip_end_x, clip_end_y, input ready);
   modport sink   (input valid, visible, clip_start_x, clip_start_y,
                   clip_end_x, clip_end_y, output ready);
endinterface

### src/lrc_prep.sv
// two front stages: edge distance and direction terms, then magnitudes and
// edge classification; depends on lrc_pkg
module lrc_prep import lrc_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  seg_req_type          seg,
   output seg_side_type         side,
   output logic [MW-1:0]        num [N_EDGES],
   output logic [MW-1:0]        den [N_EDGES]
);

   logic signed [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [DW-1:0] p_ff [N_EDGES];
   logic signed [DW-1:0] q_ff [N_EDGES];
   logic signed [DW-1:0] p_in [N_EDGES];
   logic signed [DW-1:0] q_in [N_EDGES];
   seg_side_type         side_ff, side_in;
   logic [MW-1:0]        num_ff [N_EDGES];
   logic [MW-1:0]        den_ff [N_EDGES];
   logic [MW-1:0]        num_in [N_EDGES];
   logic [MW-1:0]        den_in [N_EDGES];

   // stage a: differences
   always_comb begin
      dx_in = DW'(seg.end_x) - DW'(seg.start_x);
      dy_in = DW'(seg.end_y) - DW'(seg.start_y);
      p_in[EDGE_LEFT]   = -dx_in;
      q_in[EDGE_LEFT]   = DW'(seg.start_x) - DW'(seg.win_left);
      p_in[EDGE_RIGHT]  = dx_in;
      q_in[EDGE_RIGHT]  = DW'(seg.win_right) - DW'(seg.start_x);
      p_in[EDGE_BOTTOM] = -dy_in;
      q_in[EDGE_BOTTOM] = DW'(seg.start_y) - DW'(seg.win_bottom);
      p_in[EDGE_TOP]    = dy_in;
      q_in[EDGE_TOP]    = DW'(seg.win_top) - DW'(seg.start_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= seg.start_x;
         y1_ff <= seg.start_y;
         x2_ff <= seg.end_x;
         y2_ff <= seg.end_y;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         p_ff  <= p_in;
         q_ff  <= q_in;
      end
   end

   // stage b: magnitudes and classification
   always_comb begin
      side_in.x1 = x1_ff;
      side_in.y1 = y1_ff;
      side_in.x2 = x2_ff;
      side_in.y2 = y2_ff;
      side_in.dx = dx_ff;
      side_in.dy = dy_ff;
      for (int e = 0; e < N_EDGES; e++) begin
         num_in[e] = magnitude(q_ff[e]);
         den_in[e] = magnitude(p_ff[e]);
         side_in.cls[e].p_neg   = p_ff[e] < 0;
         side_in.cls[e].p_zero  = p_ff[e] == '0;
         side_in.cls[e].q_neg   = q_ff[e] < 0;
         side_in.cls[e].t_neg   = (q_ff[e] != '0) && ((q_ff[e] < 0) != (p_ff[e] < 0));
         side_in.cls[e].t_above = num_in[e] > den_in[e];
         side_in.cls[e].t_one   = num_in[e] == den_in[e];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign side = side_ff;
   assign num  = num_ff;
   assign den  = den_ff;

endmodule

### src/lrc_div.sv
// pipelined restoring divider, DIV_BPS (two) quotient bits per stage, fraction only
// depends on lrc_pkg
module lrc_div import lrc_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [MW-1:0]     num,
   input  logic [MW-1:0]     den,
   output logic [T_FRAC-1:0] quo
);

   logic [RW-1:0]     rem_w [DIV_STAGES+1];
   logic [T_FRAC-1:0] quo_w [DIV_STAGES+1];
   logic [MW-1:0]     den_w [DIV_STAGES+1];
   logic [RW-1:0]     rem_ff [DIV_STAGES];
   logic [T_FRAC-1:0] quo_ff [DIV_STAGES];
   logic [MW-1:0]     den_ff [DIV_STAGES];
   logic [RW-1:0]     rem_in [DIV_STAGES];
   logic [T_FRAC-1:0] quo_in [DIV_STAGES];

   assign rem_w[0] = RW'(num);
   assign quo_w[0] = '0;
   assign den_w[0] = den;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      always_comb begin
         logic [RW-1:0]     r;
         logic [T_FRAC-1:0] qv;
         r  = rem_w[s];
         qv = quo_w[s];
         for (int b = 0; b < DIV_BPS; b++) begin
            r  = r << 1;
            qv = qv << 1;
            if (r >= RW'(den_w[s])) begin
               r     = r - RW'(den_w[s]);
               qv[0] = 1'b1;
            end
         end
         rem_in[s] = r;
         quo_in[s] = qv;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_w[s];
         end
      end

      assign rem_w[s+1] = rem_ff[s];
      assign quo_w[s+1] = quo_ff[s];
      assign den_w[s+1] = den_ff[s];
   end

   assign quo = quo_w[DIV_STAGES];

endmodule

### src/lrc_lerp.sv
// two-stage endpoint interpolation: truncated product, then add to the base
// depends on lrc_pkg
module lrc_lerp import lrc_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] base,
   input  logic signed [CW-1:0] alt,
   input  logic signed [DW-1:0] d,
   input  logic signed [TW-1:0] t,
   input  logic                 move,
   input  logic                 vis,
   output logic signed [CW-1:0] coord
);

   logic [MW-1:0]          a;
   logic [CW+T_FRAC-1:0]   mul;
   logic [MW-1:0]          prod_ff, prod_in;
   logic                   dneg_ff, move_ff, vis_ff;
   logic signed [CW-1:0]   base_ff, alt_ff;
   logic signed [DW:0]     sum;
   logic signed [CW-1:0]   coord_ff, coord_in;

   always_comb begin
      a   = magnitude(d);
      mul = (CW+T_FRAC)'(a[CW-1:0]) * (CW+T_FRAC)'(t[T_FRAC-1:0]);
      priority if (t[T_FRAC])  prod_in = a;   // t is exactly one
      else if (a[MW-1])        prod_in = MW'({t[T_FRAC-1:0], {CW{1'b0}}} >> T_FRAC);
      else                     prod_in = MW'(mul >> T_FRAC);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         dneg_ff <= d < 0;
         base_ff <= base;
         alt_ff  <= alt;
         move_ff <= move;
         vis_ff  <= vis;
      end
   end

   always_comb begin
      if (dneg_ff) sum = (DW+1)'(base_ff) - signed'({1'b0, prod_ff});
      else         sum = (DW+1)'(base_ff) + signed'({1'b0, prod_ff});
      priority if (!vis_ff) coord_in = '0;
      else if (move_ff)     coord_in = sum[CW-1:0];
      else                  coord_in = alt_ff;
   end

   always_ff @(posedge clock) begin
      if (en) coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule

### src/line_rect_clip.sv
// line_rect_clip top level: Liang-Barsky clipping of one segment per request
// depends on lrc_pkg, lrc_chan_if, lrc_prep, lrc_div, lrc_lerp
//
// Clips one 2D segment (signed Q16.16 endpoints) against an axis-aligned
// window per request and returns a visible flag plus the clipped endpoints,
// all zero when the segment is rejected. Fully pipelined: a new request is
// taken every cycle unless the response register stalls, and each request
// passes the prep stages, the 16 stages of the four parallel t dividers (two
// quotient bits per stage), the edge-test stages and the interpolation stages.
// The whole pipeline advances together whenever the response register is empty
// or being taken, so a stall holds every stage in place.
module line_rect_clip import lrc_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   lrc_req_if.sink   req_chan,
   lrc_rsp_if.source rsp_chan
);

   // stage positions in the valid line
   localparam int DIV_OUT = 2 + DIV_STAGES;   // position just after the divider results
   localparam int T1_POS  = DIV_OUT;          // left and right edges
   localparam int T2_POS  = DIV_OUT + 1;      // bottom and top edges
   localparam int LAT     = DIV_OUT + 4;

   logic              en;
   logic [LAT-1:0]    vld_ff, vld_in;
   seg_req_type       seg;
   seg_side_type      prep_side;
   logic [MW-1:0]     num [N_EDGES];
   logic [MW-1:0]     den [N_EDGES];
   logic [T_FRAC-1:0] quo [N_EDGES];
   seg_side_type      side_ff [DIV_STAGES];

   // edge test stages
   clip_range_type       r_left, r_right, r_bottom, r_top;
   clip_range_type       t1_range_ff, t2_range_ff;
   seg_side_type         t1_side_ff, t2_side_ff;
   logic signed [TW-1:0] t_edge [N_EDGES];
   logic signed [TW-1:0] t1_tb_ff, t1_tt_ff;
   logic [2:0]           vis_ff;

   // whole pipeline moves while the response slot is free or being drained
   assign en             = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   assign seg.win_left   = req_chan.win_left;
   assign seg.win_right  = req_chan.win_right;
   assign seg.win_bottom = req_chan.win_bottom;
   assign seg.win_top    = req_chan.win_top;
   assign seg.start_x    = req_chan.start_x;
   assign seg.start_y    = req_chan.start_y;
   assign seg.end_x      = req_chan.end_x;
   assign seg.end_y      = req_chan.end_y;

   assign vld_in = {vld_ff[LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   lrc_prep u_prep (
      .clock (clock),
      .en    (en),
      .seg   (seg),
      .side  (prep_side),
      .num   (num),
      .den   (den)
   );

   // one divider per edge, the segment data rides alongside
   for (genvar e = 0; e < N_EDGES; e++) begin : g_div
      lrc_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num[e]),
         .den   (den[e]),
         .quo   (quo[e])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= prep_side;
         for (int s = 1; s < DIV_STAGES; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // left and right edges, in order, then bottom and top
   always_comb begin
      clip_range_type r0;
      r0.ok   = 1'b1;
      r0.tmin = T_ZERO;
      r0.tmax = T_ONE;
      for (int e = 0; e < N_EDGES; e++)
         t_edge[e] = edge_ratio(side_ff[DIV_STAGES-1].cls[e], quo[e]);
      r_left   = edge_step(side_ff[DIV_STAGES-1].cls[EDGE_LEFT], t_edge[EDGE_LEFT], r0);
      r_right  = edge_step(side_ff[DIV_STAGES-1].cls[EDGE_RIGHT], t_edge[EDGE_RIGHT],
                           r_left);
      r_bottom = edge_step(t1_side_ff.cls[EDGE_BOTTOM], t1_tb_ff, t1_range_ff);
      r_top    = edge_step(t1_side_ff.cls[EDGE_TOP], t1_tt_ff, r_bottom);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_range_ff <= r_right;
         t1_side_ff  <= side_ff[DIV_STAGES-1];
         t1_tb_ff    <= t_edge[EDGE_BOTTOM];
         t1_tt_ff    <= t_edge[EDGE_TOP];
         t2_range_ff <= r_top;
         t2_side_ff  <= t1_side_ff;
         vis_ff      <= {vis_ff[1:0], r_top.ok};
      end
   end

   // endpoint interpolation, start moves with t_min and end with t_max
   lrc_lerp u_lerp_sx (
      .clock (clock), .en (en),
      .base  (t2_side_ff.x1), .alt (t2_side_ff.x1), .d (t2_side_ff.dx),
      .t     (t2_range_ff.tmin), .move (t2_range_ff.tmin != T_ZERO),
      .vis   (t2_range_ff.ok), .coord (rsp_chan.clip_start_x)
   );

   lrc_lerp u_lerp_sy (
      .clock (clock), .en (en),
      .base  (t2_side_ff.y1), .alt (t2_side_ff.y1), .d (t2_side_ff.dy),
      .t     (t2_range_ff.tmin), .move (t2_range_ff.tmin != T_ZERO),
      .vis   (t2_range_ff.ok), .coord (rsp_chan.clip_start_y)
   );

   lrc_lerp u_lerp_ex (
      .clock (clock), .en (en),
      .base  (t2_side_ff.x1), .alt (t2_side_ff.x2), .d (t2_side_ff.dx),
      .t     (t2_range_ff.tmax), .move (t2_range_ff.tmax != T_ONE),
      .vis   (t2_range_ff.ok), .coord (rsp_chan.clip_end_x)
   );

   lrc_lerp u_lerp_ey (
      .clock (clock), .en (en),
      .base  (t2_side_ff.y1), .alt (t2_side_ff.y2), .d (t2_side_ff.dy),
      .t     (t2_range_ff.tmax), .move (t2_range_ff.tmax != T_ONE),
      .vis   (t2_range_ff.ok), .coord (rsp_chan.clip_end_y)
   );

   assign rsp_chan.valid   = vld_ff[LAT-1];
   assign rsp_chan.visible = vis_ff[2];

   // a surviving segment keeps a sane parameter window
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T2_POS] && t2_range_ff.ok |->
         t2_range_ff.tmin <= t2_range_ff.tmax && t2_range_ff.tmin >= T_ZERO &&
         t2_range_ff.tmax <= T_ONE)
      else $error("clip range out of order");

   // rejected segments come out as all zero
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.visible |->
         rsp_chan.clip_start_x == '0 && rsp_chan.clip_start_y == '0 &&
         rsp_chan.clip_end_x == '0 && rsp_chan.clip_end_y == '0)
      else $error("rejected segment with nonzero coordinates");

   // a stall freezes the valid line, as it does every stage of the pipeline
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   // the bottom-and-top entry only comes from the left-and-right entry behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      en && !vld_ff[T1_POS] |=> !vld_ff[T2_POS])
      else $error("valid appeared without a source");

endmodule
